[src/gsm_pkg.sv]
// ----------------------------------------------------------------------------
// gsm_pkg - shared constants for the grid slot map
// Operation, direction and register codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package gsm_pkg;

  // default table size and register reset values
  localparam int GSM_SLOT_COUNT     = 1024;
  localparam int GSM_PER_STRIPE_W   = 7;
  localparam logic [GSM_PER_STRIPE_W-1:0] GSM_PER_STRIPE_RST = 7'd8;

  // field widths
  localparam int GSM_ITEM_W  = 10;               // item number and result value
  localparam int GSM_SLOT_W  = 11;               // signed slot index
  localparam int GSM_ENTRY_W = GSM_ITEM_W + 1;   // {used, item}

  // operations
  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  // search directions (codes with bit 2 set are invalid)
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // configuration register indexes
  localparam logic REG_ENABLED    = 1'b0;
  localparam logic REG_PER_STRIPE = 1'b1;

endpackage

[src/gsm_ram.sv]
// ----------------------------------------------------------------------------
// gsm_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gsm_ram
  import gsm_pkg::*;
#(
  parameter int WIDTH = GSM_ENTRY_W,
  parameter int DEPTH = GSM_SLOT_COUNT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/grid_slot_map_nearest_search.sv]
// ----------------------------------------------------------------------------
// grid_slot_map_nearest_search - slot table with nearest occupied slot search
// Place, free, lookup and directional nearest search over a grid of slots.
// ----------------------------------------------------------------------------
// Sequence: a place, a free of any slot but the top one and any word answered at once
//   give a registered done word; a table lookup goes through ST_LOOK for the
//   RAM read; a search from a negative slot or a free of the top slot runs a
//   sweep of every slot, a directional search a 10-step divider, then the sweep (one slot read a cycle).
// Throughput: one command at a time, busy high until its done strobe unless answered at once; the
//   receiver cannot stall. Reset: a clearing pass over every slot, busy high.
module grid_slot_map_nearest_search
  import gsm_pkg::*;
#(
  parameter int SLOT_COUNT = GSM_SLOT_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  // command word
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic signed [GSM_SLOT_W-1:0] slot_index,
  input  logic [GSM_ITEM_W-1:0]       item_number,
  input  logic [2:0]                  direction,
  // result word
  output logic                        done,
  output logic                        found,
  output logic [GSM_ITEM_W-1:0]       value,
  // configuration
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [GSM_PER_STRIPE_W-1:0] wr_data
);

  // table address width, width for in-range compare, row and distance widths
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = (AW >= GSM_ITEM_W) ? AW + 1 : GSM_SLOT_W;
  localparam int YW = (AW > GSM_ITEM_W) ? AW : GSM_ITEM_W;
  localparam int DW = YW + 1;
  localparam int PW = GSM_PER_STRIPE_W;
  localparam int NW = $clog2(GSM_ITEM_W);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_SCAN
  } state_t;

  // what a table sweep is looking for
  typedef enum logic [1:0] {
    SM_FIRST,   // lowest occupied slot
    SM_NEAR,    // nearest occupied slot in a direction
    SM_LAST     // highest occupied slot
  } scan_mode_t;

  state_t     state;
  scan_mode_t scan_mode;

  // configuration registers
  logic          enabled;
  logic [PW-1:0] per_stripe;

  // highest occupied slot, 0 when empty
  logic [AW-1:0] last_slot;

  // latched command
  logic [1:0] dir_q;

  // divider: quotient register holds the dividend on entry
  logic [GSM_ITEM_W-1:0] div_quo;
  logic [PW-1:0]         div_rem;
  logic [NW-1:0]         div_cnt;

  // sweep address generator (also the clearing counter)
  logic          scan_issue;
  logic [AW-1:0] scan_addr;
  logic [PW-1:0] scan_px;
  logic [AW-1:0] scan_py;

  // stage A: RAM data returning
  logic          a_vld;
  logic [AW-1:0] a_slot;
  logic [PW-1:0] a_px;
  logic [AW-1:0] a_py;

  // stage B: qualified candidate with its distance
  logic          b_vld;
  logic [AW-1:0] b_slot;
  logic [DW-1:0] b_d;
  logic          b_aligned;

  // best so far
  logic          best_vld;
  logic [AW-1:0] best_slot;
  logic [DW-1:0] best_d;

  // RAM
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [GSM_ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [GSM_ENTRY_W-1:0] ram_rdata;

  logic                  rd_used;
  logic [GSM_ITEM_W-1:0] rd_item;

  // command decode
  logic          accept;
  logic [CW-1:0] slot_ext;
  logic          in_range;
  logic [AW-1:0] in_addr;
  logic          cur_beyond;
  logic [PW-1:0] cols;

  // divider step
  logic [PW:0]   div_trial;
  logic          div_ge;
  logic [PW-1:0] div_rem_next;

  // stage A compute
  logic [YW-1:0] a_py_e;
  logic [YW-1:0] cy_e;
  logic [PW-1:0] a_dx;
  logic [YW-1:0] a_dy;
  logic [DW-1:0] a_d;
  logic          a_beyond;
  logic          a_aligned;
  logic          a_qual;
  logic          b_take;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = CW'(slot_index[GSM_ITEM_W-1:0]);
  assign in_range = !slot_index[GSM_SLOT_W-1] && (slot_ext < CW'(SLOT_COUNT));
  assign in_addr  = slot_ext[AW-1:0];
  // current slot past the highest occupied slot; the empty table has last_slot 0
  assign cur_beyond = slot_ext > CW'(last_slot);
  assign cols       = (per_stripe == '0) ? PW'(1) : per_stripe;

  assign rd_used = ram_rdata[GSM_ENTRY_W-1];
  assign rd_item = ram_rdata[GSM_ITEM_W-1:0];

  // RAM port steering: clearing pass, place/free write, lookup or sweep read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = {1'b1, item_number};
    ram_raddr = (state == ST_IDLE) ? in_addr : scan_addr;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr;
      ram_wdata = '0;
    end else if (accept && in_range) begin
      if (operation == OP_PLACE) begin
        ram_we = 1'b1;
      end else if (operation == OP_FREE) begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
    end
  end

  gsm_ram #(
    .WIDTH (GSM_ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring divider step: slot / cols, one quotient bit a cycle
  assign div_trial    = {div_rem, div_quo[GSM_ITEM_W-1]};
  assign div_ge       = div_trial >= {1'b0, cols};
  assign div_rem_next = div_ge ? PW'(div_trial - {1'b0, cols}) : div_trial[PW-1:0];

  // stage A: direction test and Manhattan distance against (rem, quo)
  assign a_py_e = YW'(a_py);
  assign cy_e   = YW'(div_quo);
  assign a_dx   = (a_px >= div_rem) ? (a_px - div_rem) : (div_rem - a_px);
  assign a_dy   = (a_py_e >= cy_e) ? (a_py_e - cy_e) : (cy_e - a_py_e);
  assign a_d    = DW'(a_dx) + DW'(a_dy);

  always_comb begin
    case (dir_q)
      DIR_LEFT: begin
        a_beyond  = a_px < div_rem;
        a_aligned = a_py_e == cy_e;
      end
      DIR_RIGHT: begin
        a_beyond  = a_px > div_rem;
        a_aligned = a_py_e == cy_e;
      end
      DIR_UP: begin
        a_beyond  = a_py_e < cy_e;
        a_aligned = a_px == div_rem;
      end
      default: begin
        a_beyond  = a_py_e > cy_e;
        a_aligned = a_px == div_rem;
      end
    endcase
  end

  assign a_qual = rd_used && ((scan_mode != SM_NEAR) || a_beyond);

  // stage B: FIRST keeps first hit, LAST takes every hit, NEAR first, nearer or tie in line
  always_comb begin
    b_take = 1'b0;
    if (b_vld) begin
      unique case (scan_mode)
        SM_FIRST: b_take = !best_vld;
        SM_LAST:  b_take = 1'b1;
        SM_NEAR:  b_take = !best_vld || (b_d < best_d) || ((b_d == best_d) && b_aligned);
        default:  b_take = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan_addr  <= '0;
      scan_issue <= 1'b0;
      a_vld      <= 1'b0;
      b_vld      <= 1'b0;
      best_vld   <= 1'b0;
      done       <= 1'b0;
      found      <= 1'b0;
      value      <= '0;
      enabled    <= 1'b0;
      per_stripe <= GSM_PER_STRIPE_RST;
      last_slot  <= '0;
    end else begin
      done  <= 1'b0;
      found <= 1'b0;
      value <= '0;

      if (wr_en) begin
        unique case (wr_index)
          REG_ENABLED:    enabled    <= wr_data[0];
          REG_PER_STRIPE: per_stripe <= wr_data;
          default:        ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            // sweep and divider set up on every command; only some use them
            dir_q      <= direction[1:0];
            div_quo    <= slot_index[GSM_ITEM_W-1:0];
            div_rem    <= '0;
            div_cnt    <= '0;
            scan_addr  <= '0;
            scan_px    <= '0;
            scan_py    <= '0;
            scan_issue <= 1'b1;
            a_vld      <= 1'b0;
            b_vld      <= 1'b0;
            best_vld   <= 1'b0;
            unique case (operation)
              OP_PLACE: begin
                done <= 1'b1;
                if (in_range && (in_addr > last_slot)) begin
                  last_slot <= in_addr;
                end
              end
              OP_FREE: begin
                // freeing the top slot needs a sweep for the new top
                if (in_range && (in_addr == last_slot)) begin
                  scan_mode <= SM_LAST;
                  state     <= ST_SCAN;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_SEARCH: begin
                if (!enabled) begin
                  done <= 1'b1;
                end else if (slot_index[GSM_SLOT_W-1]) begin
                  scan_mode <= SM_FIRST;
                  state     <= ST_SCAN;
                end else if (cur_beyond || direction[2]) begin
                  done <= 1'b1;
                end else begin
                  scan_mode <= SM_NEAR;
                  state     <= ST_DIV;
                end
              end
              default: begin
                // lookup
                if (!enabled) begin
                  done  <= 1'b1;
                  found <= !slot_index[GSM_SLOT_W-1];
                  value <= slot_index[GSM_SLOT_W-1] ? '0 : slot_index[GSM_ITEM_W-1:0];
                end else if (!in_range) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_LOOK;
                end
              end
            endcase
          end
        end

        ST_LOOK: begin
          done  <= 1'b1;
          found <= rd_used;
          value <= rd_used ? rd_item : '0;
          state <= ST_IDLE;
        end

        ST_DIV: begin
          div_quo <= {div_quo[GSM_ITEM_W-2:0], div_ge};
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == NW'(GSM_ITEM_W - 1)) begin
            state <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
            if (scan_px == cols - 1'b1) begin
              scan_px <= '0;
              scan_py <= scan_py + 1'b1;
            end else begin
              scan_px <= scan_px + 1'b1;
            end
            if (scan_addr == LAST_ADDR) begin
              scan_issue <= 1'b0;
            end
          end
          a_vld     <= scan_issue;
          a_slot    <= scan_addr;
          a_px      <= scan_px;
          a_py      <= scan_py;
          b_vld     <= a_vld && a_qual;
          b_slot    <= a_slot;
          b_d       <= a_d;
          b_aligned <= a_aligned;
          if (b_take) begin
            best_vld  <= 1'b1;
            best_slot <= b_slot;
            best_d    <= b_d;
          end
          if (!scan_issue && !a_vld && !b_vld) begin
            state <= ST_IDLE;
            done  <= 1'b1;
            if (scan_mode == SM_LAST) begin
              last_slot <= best_vld ? best_slot : '0;
            end else begin
              found <= best_vld;
              value <= best_vld ? GSM_ITEM_W'(best_slot) : '0;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_place_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_PLACE)) |=> done)
    else $error("place gave no word in the next cycle");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (value == '0))
    else $error("value not zero on a not-found word");

  a_first_held: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && best_vld && (scan_mode == SM_FIRST)) |=> $stable(best_slot))
    else $error("lowest occupied slot replaced during sweep");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && scan_issue) |=> !done)
    else $error("word given while the sweep was still reading");
`endif

endmodule
